// ===== rtl/pmfb_pkg.sv =====
// shared types and constants for the page mode mono framebuffer
// operation codes, state codes, controller command and status structs
// no dependencies
package pmfb_pkg;

    localparam int STORE_DEPTH    = 512;
    localparam int MEM_AW         = 9;
    localparam int PTR_W          = 10;
    localparam int COORD_W        = 10;
    localparam int EXT_W          = 11;
    localparam int COLOR_W        = 2;
    localparam int BYTE_W         = 8;
    localparam int OP_W           = 3;
    localparam int S_DATA_W       = 56;
    localparam int DEFAULT_WIDTH  = 128;
    localparam int DEFAULT_HEIGHT = 32;

    localparam logic [COLOR_W-1:0] COLOR_CLEAR  = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_SET    = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_TOGGLE = 2'd2;
    localparam logic [COLOR_W-1:0] COLOR_NONE   = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL    = 3'd0,
        OP_FILL     = 3'd1,
        OP_SET_PTR  = 3'd2,
        OP_WR_BYTE  = 3'd3,
        OP_RD_BYTE  = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_PTR_MUL,
        ST_PTR_SET,
        ST_WR_BYTE,
        ST_RD_ISSUE,
        ST_RD_OUT,
        ST_FILL_SETUP,
        ST_FILL_PAGE,
        ST_FILL_RD,
        ST_FILL_WR
    } state_t;

    typedef struct packed {
        logic capture;
        logic clr;
        logic pix_rd;
        logic rmw_wr;
        logic ptr_mul;
        logic ptr_set;
        logic wr_byte;
        logic rd_issue;
        logic out_load;
        logic fill_setup;
        logic fill_page;
        logic fill_rd;
        logic fill_wr;
    } fb_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic fill_empty;
        logic row_end;
        logic last_page;
        logic out_free;
    } fb_stat_t;

endpackage

// ===== rtl/pmfb_datapath.sv =====
// datapath: framebuffer store, byte pointer, fill walker and output register
// driven by pmfb_ctrl through fb_cmd_t, reports through fb_stat_t
// depends on pmfb_pkg
module pmfb_datapath
    import pmfb_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = DEFAULT_WIDTH,
    parameter int DISPLAY_HEIGHT = DEFAULT_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fb_cmd_t             cmd,
    output fb_stat_t            stat,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [BYTE_W-1:0]   m_tdata,
    output logic                m_tlast
);

    localparam int PAGES    = (DISPLAY_HEIGHT + 7) / 8;
    localparam int FB_BYTES = DISPLAY_WIDTH * PAGES;
    localparam int LIMIT    = (FB_BYTES < STORE_DEPTH) ? FB_BYTES : STORE_DEPTH;
    localparam int COL_W    = $clog2(DISPLAY_WIDTH + 1);
    localparam int PG_W     = $clog2(PAGES + 1);
    localparam int FB_AW    = $clog2(FB_BYTES + 1);
    localparam int PROD_W   = COORD_W + COL_W;
    localparam int SUM_W    = PROD_W + 1;

    localparam logic [FB_AW-1:0]  LIMIT_A  = FB_AW'(LIMIT);
    localparam logic [PTR_W-1:0]  LIMIT_P  = PTR_W'(LIMIT);
    localparam logic [SUM_W-1:0]  LIMIT_S  = SUM_W'(LIMIT);
    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(LIMIT - 1);
    localparam logic [FB_AW-1:0]  W_A      = FB_AW'(DISPLAY_WIDTH);
    localparam logic [EXT_W-1:0]  W_E      = EXT_W'(DISPLAY_WIDTH);
    localparam logic [EXT_W-1:0]  H_E      = EXT_W'(DISPLAY_HEIGHT);
    localparam logic [PROD_W-1:0] W_P      = PROD_W'(DISPLAY_WIDTH);

    logic [BYTE_W-1:0] mem [STORE_DEPTH];

    logic [COORD_W-1:0] x_reg, y_reg, w_reg, h_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [BYTE_W-1:0]  data_reg;

    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [MEM_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [EXT_W-1:0]   xe_reg, xe_next, ye_reg, ye_next;
    logic [PG_W-1:0]    page_reg, page_next;
    logic [FB_AW-1:0]   base_reg, base_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [FB_AW-1:0]   faddr_reg, faddr_next;
    logic [BYTE_W-1:0]  mask_reg, mask_next;
    logic [COLOR_W-1:0] mode_reg, mode_next;
    logic               ok_reg, ok_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               last_reg, last_next;
    logic [BYTE_W-1:0]  mem_q_reg;
    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    logic               wr_en, rd_en;
    logic [MEM_AW-1:0]  wr_addr, rd_addr;
    logic [BYTE_W-1:0]  wr_data, rmw_data, page_mask;
    logic [FB_AW-1:0]   pix_addr;
    logic               pix_ok;
    logic [EXT_W-1:0]   x_sum, y_sum;
    logic [SUM_W-1:0]   ptr_sum;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg     <= s_tdata[9:0];
            y_reg     <= s_tdata[19:10];
            w_reg     <= s_tdata[29:20];
            h_reg     <= s_tdata[39:30];
            color_reg <= s_tdata[41:40];
            data_reg  <= s_tdata[49:42];
        end
    end

    // rectangle rows covered within the current page
    always_comb begin
        logic [EXT_W-1:0] row;
        for (int b = 0; b < BYTE_W; b++) begin
            row = EXT_W'({page_reg, 3'(b)});
            page_mask[b] = (row >= EXT_W'(y_reg)) && (row < ye_reg);
        end
    end

    always_comb begin
        case (mode_reg)
            COLOR_CLEAR:  rmw_data = mem_q_reg & ~mask_reg;
            COLOR_SET:    rmw_data = mem_q_reg | mask_reg;
            COLOR_TOGGLE: rmw_data = mem_q_reg ^ mask_reg;
            default:      rmw_data = mem_q_reg;
        endcase
    end

    assign pix_addr = FB_AW'(x_reg) + FB_AW'(y_reg[3 +: PG_W]) * W_A;
    assign pix_ok   = (EXT_W'(x_reg) < W_E) && (EXT_W'(y_reg) < H_E)
                      && (pix_addr < LIMIT_A) && (color_reg != COLOR_NONE);
    assign x_sum    = EXT_W'(x_reg) + EXT_W'(w_reg);
    assign y_sum    = EXT_W'(y_reg) + EXT_W'(h_reg);
    assign ptr_sum  = SUM_W'(x_reg) + SUM_W'(prod_reg);

    always_comb begin
        ptr_next     = ptr_reg;
        clr_cnt_next = clr_cnt_reg;
        prod_next    = prod_reg;
        xe_next      = xe_reg;
        ye_next      = ye_reg;
        page_next    = page_reg;
        base_next    = base_reg;
        col_next     = col_reg;
        faddr_next   = faddr_reg;
        mask_next    = mask_reg;
        mode_next    = mode_reg;
        ok_next      = ok_reg;
        rd_ok_next   = rd_ok_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        wr_en        = 1'b0;
        wr_addr      = MEM_AW'(faddr_reg);
        wr_data      = rmw_data;
        rd_en        = 1'b0;
        rd_addr      = MEM_AW'(faddr_reg);

        if (cmd.clr) begin
            wr_en        = 1'b1;
            wr_addr      = clr_cnt_reg;
            wr_data      = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.pix_rd) begin
            rd_en      = 1'b1;
            rd_addr    = MEM_AW'(pix_addr);
            faddr_next = pix_addr;
            mask_next  = BYTE_W'(1) << y_reg[2:0];
            mode_next  = color_reg;
            ok_next    = pix_ok;
        end
        if (cmd.rmw_wr) begin
            wr_en = ok_reg;
        end
        if (cmd.ptr_mul) begin
            prod_next = PROD_W'(y_reg) * W_P;
        end
        if (cmd.ptr_set) begin
            ptr_next = (ptr_sum < LIMIT_S) ? PTR_W'(ptr_sum) : LIMIT_P;
        end
        if (cmd.wr_byte) begin
            if (ptr_reg < LIMIT_P) begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[MEM_AW-1:0];
                wr_data  = data_reg;
                ptr_next = ptr_reg + 1'b1;
            end
        end
        if (cmd.rd_issue) begin
            rd_en      = 1'b1;
            rd_addr    = ptr_reg[MEM_AW-1:0];
            rd_ok_next = ptr_reg < LIMIT_P;
            last_next  = (ptr_reg < LIMIT_P) && (ptr_reg + 1'b1 >= LIMIT_P);
            ptr_next   = ((ptr_reg < LIMIT_P) && (ptr_reg + 1'b1 < LIMIT_P))
                         ? ptr_reg + 1'b1 : '0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = rd_ok_reg ? mem_q_reg : '0;
            m_last_next  = last_reg;
        end
        if (cmd.fill_setup) begin
            xe_next   = (x_sum > W_E) ? W_E : x_sum;
            ye_next   = (y_sum > H_E) ? H_E : y_sum;
            page_next = y_reg[3 +: PG_W];
            base_next = FB_AW'(y_reg[3 +: PG_W]) * W_A;
            mode_next = (color_reg != COLOR_CLEAR) ? COLOR_SET : COLOR_CLEAR;
        end
        if (cmd.fill_page) begin
            col_next   = COL_W'(x_reg);
            faddr_next = base_reg + FB_AW'(x_reg);
            mask_next  = page_mask;
        end
        if (cmd.fill_rd) begin
            rd_en   = 1'b1;
            ok_next = faddr_reg < LIMIT_A;
        end
        if (cmd.fill_wr) begin
            col_next   = col_reg + 1'b1;
            faddr_next = faddr_reg + 1'b1;
            if (stat.row_end) begin
                page_next = page_reg + 1'b1;
                base_next = base_reg + W_A;
            end
        end
    end

    assign stat.clr_done   = clr_cnt_reg == CLR_LAST;
    assign stat.fill_empty = (EXT_W'(x_reg) >= xe_reg) || (EXT_W'(y_reg) >= ye_reg);
    assign stat.row_end    = EXT_W'(col_reg) + 1'b1 >= xe_reg;
    assign stat.last_page  = EXT_W'({page_reg + 1'b1, 3'b000}) >= ye_reg;
    assign stat.out_free   = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ptr_reg     <= ptr_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        xe_reg     <= xe_next;
        ye_reg     <= ye_next;
        page_reg   <= page_next;
        base_reg   <= base_next;
        col_reg    <= col_next;
        faddr_reg  <= faddr_next;
        mask_reg   <= mask_next;
        mode_reg   <= mode_next;
        ok_reg     <= ok_next;
        rd_ok_reg  <= rd_ok_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/pmfb_ctrl.sv =====
// controller state machine for the page mode mono framebuffer
// sequences the store clear, operations and fill walk through fb_cmd_t
// depends on pmfb_pkg
module pmfb_ctrl
    import pmfb_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [OP_W-1:0] s_tuser,
    input  fb_stat_t        stat,
    output fb_cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    case (op_t'(s_tuser))
                        OP_PIXEL:   state_next = ST_PIX_RD;
                        OP_FILL:    state_next = ST_FILL_SETUP;
                        OP_SET_PTR: state_next = ST_PTR_MUL;
                        OP_WR_BYTE: state_next = ST_WR_BYTE;
                        OP_RD_BYTE: state_next = ST_RD_ISSUE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_RD: begin
                cmd.pix_rd = 1'b1;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR: begin
                cmd.rmw_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_PTR_MUL: begin
                cmd.ptr_mul = 1'b1;
                state_next  = ST_PTR_SET;
            end
            ST_PTR_SET: begin
                cmd.ptr_set = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_WR_BYTE: begin
                cmd.wr_byte = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_RD_ISSUE: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FILL_SETUP: begin
                cmd.fill_setup = 1'b1;
                state_next     = ST_FILL_PAGE;
            end
            ST_FILL_PAGE: begin
                if (stat.fill_empty) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.fill_page = 1'b1;
                    state_next    = ST_FILL_RD;
                end
            end
            ST_FILL_RD: begin
                cmd.fill_rd = 1'b1;
                state_next  = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                cmd.rmw_wr  = 1'b1;
                cmd.fill_wr = 1'b1;
                if (!stat.row_end) begin
                    state_next = ST_FILL_RD;
                end else if (stat.last_page) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_FILL_PAGE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/page_mode_mono_framebuffer.sv =====
// page mode mono framebuffer: pixel plot, rectangle fill and byte access
// top level, joins pmfb_ctrl and pmfb_datapath
// depends on pmfb_pkg, pmfb_ctrl, pmfb_datapath
//
// usage
//   s_ channel carries one operation per transaction, the op code on s_tuser
//   m_ channel returns one transaction for each read byte operation
//   pixel (x, y) lives in bit y mod 8 of byte x + (y / 8) * DISPLAY_WIDTH
// sequence from one accepted transaction to the next
//   write byte: store write; pixel plot: store read, then masked write;
//   set pointer: multiply, then add and clamp; read byte: store read,
//   then result loaded to m_tdata once the result register is free;
//   fill: setup, then unless empty per covered page a page step and per
//   column a read-modify-write of one byte; unused op codes are ignored
// reset
//   after aresetn is released the store is cleared one byte a cycle,
//   DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT / 8) bytes capped at 512, with
//   s_tready low throughout; the byte pointer starts at 0
// stalls
//   the result register holds while m_tready is low; one more read byte
//   is accepted and waits for the register to free before finishing
module page_mode_mono_framebuffer
    import pmfb_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = DEFAULT_WIDTH,
    parameter int DISPLAY_HEIGHT = DEFAULT_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // x, y, width, height, color, data_byte, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // op
    input  logic [OP_W-1:0]     s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // read_data
    output logic [BYTE_W-1:0]   m_tdata,
    output logic                m_tlast
);

    fb_cmd_t  cmd;
    fb_stat_t stat;

    pmfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    pmfb_datapath #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
